/* hdl/pnsc_pkg.sv */
// Shared types, character codes and helper functions for the path name checker.
package pnsc_pkg;

  localparam int HEAD_DEPTH = 7;

  typedef logic [7:0] byte_t;
  typedef byte_t [HEAD_DEPTH-1:0] head_t;

  // Result of scanning one word: terminator seen and verdict for it
  typedef struct packed {
    logic last;
    logic rejected;
  } scan_res_t;

  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_LT     = 8'h3C;
  localparam byte_t CH_GT     = 8'h3E;
  localparam byte_t CH_QUERY  = 8'h3F;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LOW_A  = 8'h61;
  localparam byte_t CH_LOW_Z  = 8'h7A;
  localparam byte_t CH_PIPE   = 8'h7C;
  localparam byte_t CH_DEL    = 8'h7F;
  localparam byte_t CH_C0     = 8'hC0;
  localparam byte_t CH_C1     = 8'hC1;
  localparam byte_t CH_F5     = 8'hF5;
  localparam byte_t CASE_DIFF = 8'h20;

  // Reserved device names
  localparam logic [23:0] DEV_CON     = "CON";
  localparam logic [23:0] DEV_PRN     = "PRN";
  localparam logic [23:0] DEV_AUX     = "AUX";
  localparam logic [23:0] DEV_NUL     = "NUL";
  localparam logic [23:0] DEV_COM     = "COM";
  localparam logic [23:0] DEV_LPT     = "LPT";
  localparam logic [47:0] DEV_CONIN   = "CONIN$";
  localparam logic [47:0] DEV_CLOCK   = "CLOCK$";
  localparam logic [55:0] DEV_CONOUT  = "CONOUT$";

  function automatic logic is_forbidden(byte_t c);
    return (c < CH_SPACE) || (c == CH_DEL) || (c == CH_QUOTE) || (c == CH_LT) ||
           (c == CH_GT) || (c == CH_PIPE) || (c == CH_QUERY) || (c == CH_STAR) ||
           (c == CH_COLON) || (c == CH_C0) || (c == CH_C1) || (c >= CH_F5);
  endfunction

  function automatic byte_t to_upper(byte_t c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? byte_t'(c - CASE_DIFF) : c;
  endfunction

  function automatic logic is_sep(byte_t c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

endpackage

/* hdl/pnsc_in_stage.sv */
// Input register: holds one incoming word until the scanner takes it.
module pnsc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pnsc_pkg::byte_t   in_byte,
  input  logic              take,
  output logic              held_valid,
  output pnsc_pkg::byte_t   held_byte
);
  import pnsc_pkg::*;

  logic  valid_r, valid_nxt;
  byte_t byte_r;

  // Stall while a held word is not taken this cycle
  assign in_stall  = valid_r & ~take;
  assign valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on every accepted word
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

/* hdl/pnsc_scan.sv */
// Name scanner: per-name counters and flags, and the verdict on the terminator.
module pnsc_scan #(
  parameter int MAX_NAME_LEN = 260
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pnsc_pkg::byte_t     cur_byte,
  output pnsc_pkg::scan_res_t res
);
  import pnsc_pkg::*;

  localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_LEN);

  logic [CNT_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [CNT_W-1:0] seg_cnt_r, seg_cnt_nxt;
  logic [CNT_W-1:0] pfx_cnt_r, pfx_cnt_nxt;
  logic [CNT_W-1:0] space_run_r, space_run_nxt;
  logic             dot_seen_r, dot_seen_nxt;
  logic             only_dots_r, only_dots_nxt;
  byte_t            prev_r, prev_nxt;
  head_t            head_r, head_nxt;
  logic             bad_r, bad_nxt;

  logic [CNT_W-1:0] stem_len;
  logic             device;
  logic             seg_bad;
  logic             verdict;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? CNT_W'(v + 1'b1) : v;
  endfunction

  // Match the segment base against the reserved device names
  assign stem_len = CNT_W'(pfx_cnt_r - space_run_r);

  always_comb begin
    device = 1'b0;
    if (stem_len == CNT_W'(3)) begin
      device = ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_CON) ||
               ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_PRN) ||
               ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_AUX) ||
               ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_NUL);
    end else if (stem_len == CNT_W'(4)) begin
      device = (({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_COM) ||
                ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2])} == DEV_LPT)) &&
               (head_r[3] >= CH_ZERO) && (head_r[3] <= CH_NINE);
    end else if (stem_len == CNT_W'(6)) begin
      device = ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2]),
                 to_upper(head_r[3]), to_upper(head_r[4]), to_upper(head_r[5])} == DEV_CONIN) ||
               ({to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2]),
                 to_upper(head_r[3]), to_upper(head_r[4]), to_upper(head_r[5])} == DEV_CLOCK);
    end else if (stem_len == CNT_W'(7)) begin
      device = {to_upper(head_r[0]), to_upper(head_r[1]), to_upper(head_r[2]),
                to_upper(head_r[3]), to_upper(head_r[4]), to_upper(head_r[5]),
                to_upper(head_r[6])} == DEV_CONOUT;
    end
  end

  // Segment closing checks
  assign seg_bad = (seg_cnt_r == '0) || only_dots_r || (prev_r == CH_SPACE) ||
                   (prev_r == CH_DOT) || device;

  // Verdict for a terminator word
  assign verdict = bad_r || (name_cnt_r == '0) || seg_bad || is_sep(prev_r) ||
                   (name_cnt_r >= CNT_MAX);

  assign res.last     = (cur_byte == CH_NUL);
  assign res.rejected = verdict;

  // Next state
  always_comb begin
    name_cnt_nxt  = name_cnt_r;
    seg_cnt_nxt   = seg_cnt_r;
    pfx_cnt_nxt   = pfx_cnt_r;
    space_run_nxt = space_run_r;
    dot_seen_nxt  = dot_seen_r;
    only_dots_nxt = only_dots_r;
    prev_nxt      = prev_r;
    head_nxt      = head_r;
    bad_nxt       = bad_r;
    if (cur_byte == CH_NUL) begin
      // Drop everything and start a new name
      name_cnt_nxt  = '0;
      seg_cnt_nxt   = '0;
      pfx_cnt_nxt   = '0;
      space_run_nxt = '0;
      dot_seen_nxt  = 1'b0;
      only_dots_nxt = 1'b1;
      prev_nxt      = CH_NUL;
      head_nxt      = '0;
      bad_nxt       = 1'b0;
    end else if (is_sep(cur_byte)) begin
      // Close the segment
      bad_nxt       = bad_r || (name_cnt_r == '0) || seg_bad;
      seg_cnt_nxt   = '0;
      pfx_cnt_nxt   = '0;
      space_run_nxt = '0;
      dot_seen_nxt  = 1'b0;
      only_dots_nxt = 1'b1;
      head_nxt      = '0;
      name_cnt_nxt  = sat_inc(name_cnt_r);
      prev_nxt      = cur_byte;
    end else begin
      // Extend the segment
      bad_nxt = bad_r || is_forbidden(cur_byte);
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        if (seg_cnt_r == CNT_W'(i)) begin
          head_nxt[i] = cur_byte;
        end
      end
      if (cur_byte != CH_DOT) begin
        only_dots_nxt = 1'b0;
      end
      if (!dot_seen_r) begin
        if (cur_byte == CH_DOT) begin
          dot_seen_nxt = 1'b1;
        end else begin
          pfx_cnt_nxt   = sat_inc(pfx_cnt_r);
          space_run_nxt = (cur_byte == CH_SPACE) ? sat_inc(space_run_r) : '0;
        end
      end
      seg_cnt_nxt  = sat_inc(seg_cnt_r);
      name_cnt_nxt = sat_inc(name_cnt_r);
      prev_nxt     = cur_byte;
    end
  end

  // Advance state on each word taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_cnt_r  <= '0;
      seg_cnt_r   <= '0;
      pfx_cnt_r   <= '0;
      space_run_r <= '0;
      dot_seen_r  <= 1'b0;
      only_dots_r <= 1'b1;
      prev_r      <= CH_NUL;
      head_r      <= '0;
      bad_r       <= 1'b0;
    end else if (step) begin
      name_cnt_r  <= name_cnt_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      pfx_cnt_r   <= pfx_cnt_nxt;
      space_run_r <= space_run_nxt;
      dot_seen_r  <= dot_seen_nxt;
      only_dots_r <= only_dots_nxt;
      prev_r      <= prev_nxt;
      head_r      <= head_nxt;
      bad_r       <= bad_nxt;
    end
  end

endmodule

/* hdl/pnsc_out_stage.sv */
// Result register: holds one verdict word until the receiver takes it.
module pnsc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pnsc_pkg::scan_res_t res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_rejected
);
  import pnsc_pkg::*;

  logic valid_r, valid_nxt;
  logic rejected_r;

  // Room for a new verdict when empty or when the held one leaves now
  assign free = ~valid_r | ~out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the verdict
  always_ff @(posedge clk) begin
    if (load) begin
      rejected_r <= res.rejected;
    end
  end

  assign out_valid    = valid_r;
  assign out_rejected = rejected_r;

endmodule

/* hdl/path_name_safety_checker_top.sv */
// Path name safety checker: one name byte per word in, one verdict per name out.
// Throughput: one byte word per cycle, sustained, while the result side is not stalled.
// A terminator goes through the input register, then scan logic into the result register,
// which drives out_valid; it waits while the result register is full and stalled.
// Reset: rst_n synchronous active low; clears both stage valids and all name state.
module path_name_safety_checker_top #(
  parameter int MAX_NAME_LEN = 260
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_char_code,
  output logic out_valid,
  input  logic out_stall,
  output logic out_rejected
);
  import pnsc_pkg::*;

  logic      held_valid;
  byte_t     held_byte;
  scan_res_t res;
  logic      out_free;
  logic      take;

  // Take a held word unless it is a terminator with the result register full and stalled
  assign take = held_valid & (~res.last | out_free);

  pnsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_char_code),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pnsc_scan #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (take),
    .cur_byte (held_byte),
    .res      (res)
  );

  pnsc_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (take & res.last),
    .res          (res),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rejected (out_rejected)
  );

endmodule
